// ----- src/bspline_de_boor_evaluator_unit_macros.svh -----
// Assertion macros used by the top RTL file of the evaluator.
`ifndef BSPLINE_DE_BOOR_EVALUATOR_UNIT_MACROS_SVH
`define BSPLINE_DE_BOOR_EVALUATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define BSDE_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define BSDE_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("assertion failed");
`else
`define BSDE_ASSERT_NOW(lbl, ant, cons)
`define BSDE_ASSERT_NEXT(lbl, ant, cons)
`endif
`endif

// ----- src/bsde_pkg.sv -----
`default_nettype none
package bsde_pkg;

  localparam int MAX_KNOTS_DEF  = 256;
  localparam int MAX_DEGREE_DEF = 5;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [1:0] KIND_KNOT = 2'd0;
  localparam logic [1:0] KIND_COEF = 2'd1;
  localparam logic [1:0] KIND_EVAL = 2'd2;

  localparam logic REG_DEGREE    = 1'b0;
  localparam logic REG_LAST_KNOT = 1'b1;

  localparam logic [2:0] DEGREE_RESET    = 3'd2;
  localparam logic [7:0] LAST_KNOT_RESET = 8'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         slot;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] spline_value;
    logic [7:0]         interval;
    logic               status;
  } out_beat_t;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic go;
    logic done;
  } div_ctl_t;

endpackage
`default_nettype wire

// ----- src/bsde_ram.sv -----
`default_nettype none
module bsde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/bsde_div.sv -----
`default_nettype none
// Restoring unsigned divider, one quotient bit per cycle.
module bsde_div #(
  parameter int FRAC_BITS = bsde_pkg::FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    go,
  input  wire logic [33+FRAC_BITS-1:0] dvd,
  input  wire logic [32:0]             dsr,
  output bsde_pkg::div_ctl_t           ctl,
  output logic [33+FRAC_BITS-1:0]      quo
);
  import bsde_pkg::*;

  localparam int NB = 33 + FRAC_BITS;
  localparam int CW = $clog2(NB + 1);

  logic [NB-1:0] q_r, q_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [32:0]   dsr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [33:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[NB-1]} - {1'b0, dsr_r};
    if (go) begin
      q_nxt   = dvd;
      rem_nxt = '0;
      cnt_nxt = CW'(NB);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
      end else begin
        rem_nxt = {rem_r[31:0], q_r[NB-1]};
      end
      q_nxt   = {q_r[NB-2:0], ~trial[33]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (go) begin
      dsr_r <= dsr;
    end
  end

  assign ctl.go   = go;
  assign ctl.done = done_r;
  assign quo      = q_r;
endmodule
`default_nettype wire

// ----- src/bspline_de_boor_evaluator_unit.sv -----
`default_nettype none
// Write beats (knot or coefficient) leave busy low.
// An evaluate beat does s search probes (s up to log2(N)), deg+1 coefficient loads,
// deg*(deg+1)/2 live triangle steps through the divider, as many plain realign
// steps and one result state; the next beat is taken after the result.
// Reset (synchronous, rst_n low) returns the sequencer to idle and the registers to
// degree 2 and last knot index 2; the stores keep their contents. Results cannot stall.
`include "bspline_de_boor_evaluator_unit_macros.svh"
module bspline_de_boor_evaluator_unit #(
  parameter int MAX_KNOTS  = bsde_pkg::MAX_KNOTS_DEF,
  parameter int MAX_DEGREE = bsde_pkg::MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = bsde_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire bsde_pkg::in_beat_t in_beat,
  output logic                    out_valid,
  output bsde_pkg::out_beat_t     out_beat,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [7:0]         cfg_data
);
  import bsde_pkg::*;

  // Store address width, index width wide enough for every index the
  // recurrence forms, and a signed version of it for the search bounds.
  localparam int AW = $clog2(MAX_KNOTS);
  localparam int IW = ((AW > 8) ? AW : 8) + 2;
  localparam int SW = IW + 1;
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int NB = 33 + FRAC_BITS;
  localparam logic signed [SW-1:0] KNOTS_S = SW'(MAX_KNOTS);

  // The sequencer walks: search, coefficient load, then for each triangle
  // step two knot reads, a divide, a multiply, a rounding and an accumulate.
  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_SRCH = 14'b00000000000010,
    S_SCMP = 14'b00000000000100,
    S_LRD  = 14'b00000000001000,
    S_LCAP = 14'b00000000010000,
    S_URD  = 14'b00000000100000,
    S_VRD  = 14'b00000001000000,
    S_PREP = 14'b00000010000000,
    S_DIV  = 14'b00000100000000,
    S_MUL  = 14'b00001000000000,
    S_RND  = 14'b00010000000000,
    S_ACC  = 14'b00100000000000,
    S_DONE = 14'b01000000000000,
    S_ROT  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0] degree_r;
  logic [7:0] last_knot_r;

  logic signed [31:0] x_r;
  logic [DW-1:0]      deg_r, c_r, c_nxt, j_r, j_nxt;
  logic signed [SW-1:0] k_r, k_nxt, n_r, n_nxt, mid_r, mid_nxt;
  logic signed [31:0] d_r [MAX_DEGREE+1];
  logic signed [31:0] d_nxt [MAX_DEGREE+1];
  logic signed [31:0] u_r, alpha_r, alpha_nxt, sat_r, sat_nxt;
  logic signed [64:0] prod_r, scl_r;
  logic               neg_r, neg_nxt, status_r, status_nxt;

  // Memory side.
  logic signed [SW-1:0] knot_idx, coef_idx;
  logic                 knot_oob_r, coef_oob_r;
  logic [31:0]          knot_rd, coef_rd;
  logic signed [31:0]   knot_q, coef_q;
  logic                 wr_ok;
  logic [IW-1:0]        slot_ext;
  logic                 accept;

  // Datapath temporaries.
  logic [DW-1:0]        deg_in;
  logic signed [32:0]   num, den, diff;
  logic [32:0]          num_mag, den_mag;
  logic signed [65:0]   sum;
  logic signed [31:0]   new_d;
  logic                 do_rot, rot_plain;
  logic signed [SW-1:0] deg_s, j_s, c_s;
  logic                 div_go;
  div_ctl_t             div_ctl;
  logic [NB-1:0]        div_q;
  logic                 last_step;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r    <= DEGREE_RESET;
      last_knot_r <= LAST_KNOT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEGREE:    degree_r    <= cfg_data[2:0];
        REG_LAST_KNOT: last_knot_r <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Degree zero acts as one; above the supported maximum it is clipped.
  always_comb begin
    if (degree_r == 3'd0) begin
      deg_in = DW'(1);
    end else if (32'(degree_r) > MAX_DEGREE) begin
      deg_in = DW'(MAX_DEGREE);
    end else begin
      deg_in = DW'(degree_r);
    end
  end

  assign deg_s = $signed({{(SW-DW){1'b0}}, deg_r});
  assign j_s   = $signed({{(SW-DW){1'b0}}, j_r});
  assign c_s   = $signed({{(SW-DW){1'b0}}, c_r});

  // Stores: writes come only from accepted write beats.
  assign slot_ext = IW'(in_beat.slot);
  assign wr_ok    = accept && (slot_ext < IW'(MAX_KNOTS));

  // Knot read index: the midpoint while searching, u[i] for S_URD and
  // u[i+deg+1-j] = knot[k+1+c] for S_VRD.
  always_comb begin
    case (state_r)
      S_SRCH:  knot_idx = (n_r + k_r) >>> 1;
      S_URD:   knot_idx = k_r - deg_s + j_s + c_s;
      default: knot_idx = k_r + SW'(1) + c_s;
    endcase
  end
  assign coef_idx = k_r - deg_s + c_s;

  bsde_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_knot_ram (
    .clk   (clk),
    .we    (wr_ok && (in_beat.kind == KIND_KNOT)),
    .waddr (slot_ext[AW-1:0]),
    .wdata (in_beat.value),
    .raddr (knot_idx[AW-1:0]),
    .rdata (knot_rd)
  );

  bsde_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_coef_ram (
    .clk   (clk),
    .we    (wr_ok && (in_beat.kind == KIND_COEF)),
    .waddr (slot_ext[AW-1:0]),
    .wdata (in_beat.value),
    .raddr (coef_idx[AW-1:0]),
    .rdata (coef_rd)
  );

  // A read past the end of a store yields zero.
  always_ff @(posedge clk) begin
    knot_oob_r <= (knot_idx >= KNOTS_S);
    coef_oob_r <= (coef_idx >= KNOTS_S);
  end
  assign knot_q = knot_oob_r ? 32'sd0 : $signed(knot_rd);
  assign coef_q = coef_oob_r ? 32'sd0 : $signed(coef_rd);

  // Alpha numerator and denominator; the divider works on magnitudes.
  assign num     = 33'(x_r) - 33'(u_r);
  assign den     = 33'(knot_q) - 33'(u_r);
  assign num_mag = num[32] ? 33'(-num) : num;
  assign den_mag = den[32] ? 33'(-den) : den;
  assign div_go  = (state_r == S_PREP) && (den != 33'sd0);

  bsde_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .dvd   ({num_mag, {FRAC_BITS{1'b0}}}),
    .dsr   (den_mag),
    .ctl   (div_ctl),
    .quo   (div_q)
  );

  // Quotient saturation to signed 32 bits after truncation toward zero.
  always_comb begin
    if (neg_r) begin
      if (div_q > NB'(33'h080000000)) begin
        alpha_nxt = 32'sh80000000;
      end else begin
        alpha_nxt = 32'(-div_q);
      end
    end else if (div_q > NB'(33'h07fffffff)) begin
      alpha_nxt = 32'sh7fffffff;
    end else begin
      alpha_nxt = 32'(div_q);
    end
  end

  assign diff = 33'(d_r[1]) - 33'(d_r[0]);
  assign sum  = 66'(d_r[0]) + 66'(scl_r);
  always_comb begin
    if (sum > 66'sh0007fffffff) begin
      new_d = 32'sh7fffffff;
    end else if (sum < -66'sh00080000000) begin
      new_d = 32'sh80000000;
    end else begin
      new_d = 32'(sum);
    end
  end

  // The coefficient line is a rotating register: entry deg takes the new
  // value and every other entry takes its upper neighbor, so the recurrence
  // only ever reads entries 0 and 1.
  assign last_step = (c_r == deg_r);

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    n_nxt      = n_r;
    mid_nxt    = mid_r;
    c_nxt      = c_r;
    j_nxt      = j_r;
    status_nxt = status_r;
    sat_nxt    = sat_r;
    neg_nxt    = neg_r;
    do_rot     = 1'b0;
    rot_plain  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_beat.kind == KIND_EVAL)) begin
          state_nxt  = S_SRCH;
          k_nxt      = $signed({{(SW-DW){1'b0}}, deg_in});
          n_nxt      = $signed({{(SW-8){1'b0}}, last_knot_r})
                     - $signed({{(SW-DW){1'b0}}, deg_in});
          status_nxt = 1'b0;
        end
      end
      S_SRCH: begin
        if (n_r - k_r > SW'(1)) begin
          mid_nxt   = knot_idx;
          state_nxt = S_SCMP;
        end else begin
          c_nxt     = '0;
          state_nxt = S_LRD;
        end
      end
      S_SCMP: begin
        if (x_r < knot_q) begin
          n_nxt = mid_r;
        end else begin
          k_nxt = mid_r;
        end
        state_nxt = S_SRCH;
      end
      S_LRD: state_nxt = S_LCAP;
      S_LCAP: begin
        do_rot = 1'b1;
        if (last_step) begin
          c_nxt     = '0;
          j_nxt     = DW'(1);
          state_nxt = S_ROT;
        end else begin
          c_nxt     = c_r + 1'b1;
          state_nxt = S_LRD;
        end
      end
      S_ROT: begin
        // Past the last live entry of this pass: realign without work.
        if (c_r > deg_r - j_r) begin
          do_rot    = 1'b1;
          rot_plain = 1'b1;
          if (last_step) begin
            c_nxt = '0;
            if (j_r == deg_r) begin
              state_nxt = S_DONE;
            end else begin
              j_nxt = j_r + 1'b1;
            end
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end else begin
          state_nxt = S_URD;
        end
      end
      S_URD: state_nxt = S_VRD;
      S_VRD: state_nxt = S_PREP;
      S_PREP: begin
        if (den == 33'sd0) begin
          status_nxt = 1'b1;
          sat_nxt    = num[32] ? 32'sh80000000 : 32'sh7fffffff;
          state_nxt  = S_DONE;
        end else begin
          neg_nxt   = num[32] ^ den[32];
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_ctl.done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: state_nxt = S_RND;
      S_RND: state_nxt = S_ACC;
      S_ACC: begin
        do_rot    = 1'b1;
        c_nxt     = c_r + 1'b1;
        state_nxt = S_ROT;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    for (int m = 0; m <= MAX_DEGREE; m++) begin
      d_nxt[m] = d_r[m];
      if (do_rot) begin
        if (DW'(m) == deg_r) begin
          if (rot_plain) begin
            d_nxt[m] = d_r[0];
          end else if (state_r == S_ACC) begin
            d_nxt[m] = new_d;
          end else begin
            d_nxt[m] = coef_q;
          end
        end else if (m < MAX_DEGREE) begin
          d_nxt[m] = d_r[m+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (accept && (in_beat.kind == KIND_EVAL)) begin
      x_r   <= in_beat.value;
      deg_r <= deg_in;
    end
    k_r      <= k_nxt;
    n_r      <= n_nxt;
    mid_r    <= mid_nxt;
    c_r      <= c_nxt;
    j_r      <= j_nxt;
    status_r <= status_nxt;
    sat_r    <= sat_nxt;
    neg_r    <= neg_nxt;
    d_r      <= d_nxt;
    if (state_r == S_VRD) begin
      u_r <= knot_q;
    end
    if (div_ctl.done) begin
      alpha_r <= alpha_nxt;
    end
    if (state_r == S_MUL) begin
      prod_r <= 65'(alpha_r) * 65'(diff);
    end
    if (state_r == S_RND) begin
      scl_r <= (prod_r + (65'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    end
  end

  // The result beat shows for the single cycle spent in S_DONE.
  assign out_valid             = (state_r == S_DONE);
  assign out_beat.spline_value = status_r ? sat_r : d_r[0];
  assign out_beat.interval     = k_r[7:0];
  assign out_beat.status       = status_r;

  `BSDE_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  `BSDE_ASSERT_NEXT(a_eval_goes_busy, accept && (in_beat.kind == KIND_EVAL), busy)
  `BSDE_ASSERT_NOW(a_div_only_in_div, div_ctl.done, state_r == S_DIV)
  `BSDE_ASSERT_NOW(a_interval_floor, out_valid, k_r >= deg_s)
endmodule
`default_nettype wire
